[sv/vmt_pkg.sv]
// Shared types and constants for the vertex matrix transform.
`default_nettype none
package vmt_pkg;
	localparam int NUM_REGS = 8;
	localparam int REG_WIDTH = 64;
	localparam int IDX_WIDTH = 3;
	localparam int ENT_WIDTH = 32;
	localparam int FIELD_WIDTH = 32;

	typedef enum logic [1:0] {
		ACT_FULL = 2'd0,
		ACT_ROT = 2'd1,
		ACT_INVROT = 2'd2,
		ACT_NONE = 2'd3
	} action_t;

	typedef enum logic [IDX_WIDTH-1:0] {
		REG_M11_M12 = 3'd0,
		REG_M13_M14 = 3'd1,
		REG_M21_M22 = 3'd2,
		REG_M23_M24 = 3'd3,
		REG_M31_M32 = 3'd4,
		REG_M33_M34 = 3'd5,
		REG_M41_M42 = 3'd6,
		REG_M43_M44 = 3'd7
	} reg_idx_t;

	// per-point sideband carried alongside the divider pipeline
	typedef struct packed {
		logic valid;
		logic fault;
		logic full;
		logic clip;
	} lane_ctl_t;
endpackage
`default_nettype wire

[sv/vmt_dot_lane.sv]
// One lane: three products, floor shift, sum with an offset term.
`default_nettype none
module vmt_dot_lane #(
	parameter int FRAC_BITS = 16,
	parameter int COORD_WIDTH = 32,
	parameter int SUM_WIDTH = 68
) (
	input wire logic clk,
	input wire logic en,
	input wire logic signed [COORD_WIDTH-1:0] vx,
	input wire logic signed [COORD_WIDTH-1:0] vy,
	input wire logic signed [COORD_WIDTH-1:0] vz,
	input wire logic signed [vmt_pkg::ENT_WIDTH-1:0] ex,
	input wire logic signed [vmt_pkg::ENT_WIDTH-1:0] ey,
	input wire logic signed [vmt_pkg::ENT_WIDTH-1:0] ez,
	input wire logic signed [vmt_pkg::ENT_WIDTH-1:0] offs,
	output logic signed [SUM_WIDTH-1:0] sum
);
	localparam int PW = COORD_WIDTH + vmt_pkg::ENT_WIDTH;

	logic signed [PW-1:0] px_s1, py_s1, pz_s1;
	logic signed [vmt_pkg::ENT_WIDTH-1:0] offs_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1 <= vx * ex;
			py_s1 <= vy * ey;
			pz_s1 <= vz * ez;
			offs_s1 <= offs;
		end
	end

	// arithmetic shift is floor rounding
	always_comb begin
		sum = SUM_WIDTH'(px_s1 >>> FRAC_BITS) + SUM_WIDTH'(py_s1 >>> FRAC_BITS)
			+ SUM_WIDTH'(pz_s1 >>> FRAC_BITS) + SUM_WIDTH'(offs_s1);
	end
endmodule
`default_nettype wire

[sv/vmt_div_lane.sv]
// Pipelined restoring divider with saturation, one quotient bit per stage.
`default_nettype none
module vmt_div_lane #(
	parameter int FRAC_BITS = 16,
	parameter int COORD_WIDTH = 32,
	parameter int SUM_WIDTH = 68
) (
	input wire logic clk,
	input wire logic en,
	input wire logic signed [SUM_WIDTH-1:0] num,
	input wire logic signed [SUM_WIDTH-1:0] den,
	input wire logic full,
	output logic signed [COORD_WIDTH-1:0] res,
	output logic clip
);
	// quotient magnitude can need SUM_WIDTH + FRAC_BITS bits; we keep
	// only COORD_WIDTH+1 of them and flag anything above as overflow
	localparam int QB = COORD_WIDTH + 1;
	localparam int NB = SUM_WIDTH + FRAC_BITS;
	localparam int ST = NB;

	logic [NB-1:0] n_q [ST+1];
	logic [SUM_WIDTH-1:0] d_q [ST+1];
	logic [SUM_WIDTH:0] r_q [ST+1];
	logic [QB-1:0] q_q [ST+1];
	logic ov_q [ST+1];
	logic neg_q [ST+1];
	logic full_q [ST+1];

	logic [SUM_WIDTH-1:0] un, ud;
	always_comb begin
		un = num[SUM_WIDTH-1] ? SUM_WIDTH'(-num) : num;
		ud = den[SUM_WIDTH-1] ? SUM_WIDTH'(-den) : den;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_q[0] <= {un, FRAC_BITS'(0)};
			d_q[0] <= ud;
			r_q[0] <= '0;
			q_q[0] <= '0;
			ov_q[0] <= 1'b0;
			neg_q[0] <= num[SUM_WIDTH-1] ^ den[SUM_WIDTH-1];
			full_q[0] <= full;
		end
	end

	for (genvar i = 0; i < ST; i++) begin : g_st
		logic [SUM_WIDTH+1:0] trial;
		logic take;
		always_comb begin
			trial = {r_q[i], n_q[i][NB-1]};
			take = trial >= {2'b00, d_q[i]};
		end
		always_ff @(posedge clk) begin
			if (en) begin
				n_q[i+1] <= n_q[i] << 1;
				d_q[i+1] <= d_q[i];
				r_q[i+1] <= take ? (SUM_WIDTH+1)'(trial - {2'b00, d_q[i]})
					: (SUM_WIDTH+1)'(trial);
				q_q[i+1] <= {q_q[i][QB-2:0], take};
				ov_q[i+1] <= ov_q[i] | q_q[i][QB-1];
				neg_q[i+1] <= neg_q[i];
				full_q[i+1] <= full_q[i];
			end
		end
	end

	logic [QB-1:0] maxmag;
	logic over;
	always_comb begin
		maxmag = neg_q[ST] ? QB'(1) << (COORD_WIDTH-1) : (QB'(1) << (COORD_WIDTH-1)) - QB'(1);
		over = ov_q[ST] || (q_q[ST] > maxmag);
		if (over) begin
			res = neg_q[ST] ? COORD_WIDTH'(-maxmag) : COORD_WIDTH'(maxmag);
		end else begin
			res = neg_q[ST] ? COORD_WIDTH'(-q_q[ST]) : COORD_WIDTH'(q_q[ST]);
		end
		clip = over & full_q[ST];
	end
endmodule
`default_nettype wire

[sv/vertex_matrix_transform_unit.sv]
// Top level: config registers, four dot lanes, divider lanes, merge and output stage.
`default_nettype none
// Accepts one point per clock while the output register is free or
// being drained. SW, the sum width, is 52 bits at the defaults; the
// restoring divider pipeline retires one quotient bit per stage.
// Four lanes form X, Y, Z and W in parallel; rotate actions ride through
// the same pipeline and skip the divide result. The whole pipeline
// advances only when the output register is free or being drained.
module vertex_matrix_transform_unit #(
	parameter int FRAC_BITS = 16,
	parameter int COORD_WIDTH = 32
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [vmt_pkg::IDX_WIDTH-1:0] cfg_index,
	input wire logic [vmt_pkg::REG_WIDTH-1:0] cfg_data,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [1:0] action,
	input wire logic signed [vmt_pkg::FIELD_WIDTH-1:0] vec_x,
	input wire logic signed [vmt_pkg::FIELD_WIDTH-1:0] vec_y,
	input wire logic signed [vmt_pkg::FIELD_WIDTH-1:0] vec_z,
	output logic out_valid,
	input wire logic out_ready,
	output logic signed [vmt_pkg::FIELD_WIDTH-1:0] out_x,
	output logic signed [vmt_pkg::FIELD_WIDTH-1:0] out_y,
	output logic signed [vmt_pkg::FIELD_WIDTH-1:0] out_z,
	output logic divide_fault,
	output logic saturated
);
	localparam int EW = vmt_pkg::ENT_WIDTH;
	localparam int SW = COORD_WIDTH + EW - FRAC_BITS + 4;
	localparam int LAT = SW + FRAC_BITS + 1;
	localparam logic [EW-1:0] ONE = EW'(1) << FRAC_BITS;

	logic [vmt_pkg::REG_WIDTH-1:0] regs_q [vmt_pkg::NUM_REGS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q[vmt_pkg::REG_M11_M12] <= {ONE, EW'(0)};
			regs_q[vmt_pkg::REG_M13_M14] <= '0;
			regs_q[vmt_pkg::REG_M21_M22] <= {EW'(0), ONE};
			regs_q[vmt_pkg::REG_M23_M24] <= '0;
			regs_q[vmt_pkg::REG_M31_M32] <= '0;
			regs_q[vmt_pkg::REG_M33_M34] <= {ONE, EW'(0)};
			regs_q[vmt_pkg::REG_M41_M42] <= '0;
			regs_q[vmt_pkg::REG_M43_M44] <= {EW'(0), ONE};
		end else if (cfg_we) begin
			regs_q[cfg_index] <= cfg_data;
		end
	end

	// m[r][c], r,c 0..3
	logic signed [EW-1:0] m [4][4];
	always_comb begin
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				m[r][c] = c[0] ? regs_q[r*2 + c/2][EW-1:0]
					: regs_q[r*2 + c/2][2*EW-1:EW];
			end
		end
	end

	logic adv;
	logic signed [COORD_WIDTH-1:0] vx, vy, vz;
	vmt_pkg::action_t act;
	always_comb begin
		vx = vec_x[COORD_WIDTH-1:0];
		vy = vec_y[COORD_WIDTH-1:0];
		vz = vec_z[COORD_WIDTH-1:0];
		act = vmt_pkg::action_t'(action);
	end

	// lane coefficient selection
	logic signed [EW-1:0] cx [4], cy [4], cz [4], co [4];
	always_comb begin
		for (int c = 0; c < 4; c++) begin
			unique case (act)
				vmt_pkg::ACT_INVROT: begin
					cx[c] = (c < 3) ? m[c][0] : '0;
					cy[c] = (c < 3) ? m[c][1] : '0;
					cz[c] = (c < 3) ? m[c][2] : '0;
					co[c] = '0;
				end
				vmt_pkg::ACT_ROT: begin
					cx[c] = m[0][c];
					cy[c] = m[1][c];
					cz[c] = m[2][c];
					co[c] = '0;
				end
				vmt_pkg::ACT_FULL: begin
					cx[c] = m[0][c];
					cy[c] = m[1][c];
					cz[c] = m[2][c];
					co[c] = m[3][c];
				end
				default: begin
					cx[c] = '0;
					cy[c] = '0;
					cz[c] = '0;
					co[c] = '0;
				end
			endcase
		end
	end

	logic signed [SW-1:0] sum [4];
	for (genvar c = 0; c < 4; c++) begin : g_dot
		vmt_dot_lane #(.FRAC_BITS(FRAC_BITS), .COORD_WIDTH(COORD_WIDTH), .SUM_WIDTH(SW))
		u_dot (.clk(clk), .en(adv), .vx(vx), .vy(vy), .vz(vz),
			.ex(cx[c]), .ey(cy[c]), .ez(cz[c]), .offs(co[c]), .sum(sum[c]));
	end

	// control pipeline alongside the lanes
	vmt_pkg::lane_ctl_t ctl_q [LAT+1];
	logic [1:0] act_q [LAT+1];
	logic signed [COORD_WIDTH-1:0] rs_q [3][LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= LAT; i++) begin
				ctl_q[i] <= '0;
				act_q[i] <= '0;
			end
		end else if (adv) begin
			ctl_q[0] <= '{valid: in_valid, fault: 1'b0, full: 1'b0, clip: 1'b0};
			act_q[0] <= action;
			ctl_q[1] <= '{valid: ctl_q[0].valid,
				fault: (act_q[0] == vmt_pkg::ACT_FULL) && (sum[3] == '0),
				full: act_q[0] == vmt_pkg::ACT_FULL,
				clip: ctl_q[0].clip};
			act_q[1] <= act_q[0];
			for (int i = 2; i <= LAT; i++) begin
				ctl_q[i] <= ctl_q[i-1];
				act_q[i] <= act_q[i-1];
			end
		end
	end

	// rotate path saturation, delayed to align with divider
	logic signed [COORD_WIDTH-1:0] rsat [3];
	logic rclip;
	localparam logic signed [SW-1:0] HI = (SW'(1) << (COORD_WIDTH-1)) - SW'(1);
	localparam logic signed [SW-1:0] LO = -HI - SW'(1);
	always_comb begin
		rclip = 1'b0;
		for (int k = 0; k < 3; k++) begin
			if (sum[k] > HI) begin
				rsat[k] = COORD_WIDTH'(HI);
				rclip = 1'b1;
			end else if (sum[k] < LO) begin
				rsat[k] = COORD_WIDTH'(LO);
				rclip = 1'b1;
			end else begin
				rsat[k] = COORD_WIDTH'(sum[k]);
			end
		end
	end

	logic rclip_q [LAT];
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				rs_q[k][0] <= rsat[k];
				for (int i = 1; i < LAT; i++) rs_q[k][i] <= rs_q[k][i-1];
			end
			rclip_q[0] <= rclip;
			for (int i = 1; i < LAT; i++) rclip_q[i] <= rclip_q[i-1];
		end
	end

	// divider lanes; zero W is replaced by one to keep the lane defined
	logic signed [SW-1:0] den;
	logic signed [COORD_WIDTH-1:0] dres [3];
	logic dclip [3];
	always_comb den = (sum[3] == '0) ? SW'(1) : sum[3];
	for (genvar k = 0; k < 3; k++) begin : g_div
		vmt_div_lane #(.FRAC_BITS(FRAC_BITS), .COORD_WIDTH(COORD_WIDTH), .SUM_WIDTH(SW))
		u_div (.clk(clk), .en(adv), .num(sum[k]), .den(den), .full(1'b1),
			.res(dres[k]), .clip(dclip[k]));
	end

	// merge stage
	vmt_pkg::lane_ctl_t tail;
	logic [1:0] tact;
	logic out_v_q;
	always_comb begin
		tail = ctl_q[LAT];
		tact = act_q[LAT];
		adv = !out_v_q || out_ready;
		in_ready = adv;
	end

	logic signed [COORD_WIDTH-1:0] rx_q, ry_q, rz_q;
	logic fault_q, sat_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			fault_q <= 1'b0;
			sat_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= tail.valid;
			fault_q <= tail.fault;
			unique case (tact)
				vmt_pkg::ACT_FULL: sat_q <= !tail.fault && (dclip[0] | dclip[1] | dclip[2]);
				vmt_pkg::ACT_ROT, vmt_pkg::ACT_INVROT: sat_q <= rclip_q[LAT-1];
				default: sat_q <= 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			unique case (tact)
				vmt_pkg::ACT_FULL: begin
					rx_q <= tail.fault ? '0 : dres[0];
					ry_q <= tail.fault ? '0 : dres[1];
					rz_q <= tail.fault ? '0 : dres[2];
				end
				vmt_pkg::ACT_ROT, vmt_pkg::ACT_INVROT: begin
					rx_q <= rs_q[0][LAT-1];
					ry_q <= rs_q[1][LAT-1];
					rz_q <= rs_q[2][LAT-1];
				end
				default: begin
					rx_q <= '0;
					ry_q <= '0;
					rz_q <= '0;
				end
			endcase
		end
	end

	always_comb begin
		out_valid = out_v_q;
		out_x = vmt_pkg::FIELD_WIDTH'(rx_q);
		out_y = vmt_pkg::FIELD_WIDTH'(ry_q);
		out_z = vmt_pkg::FIELD_WIDTH'(rz_q);
		divide_fault = fault_q;
		saturated = sat_q;
	end

	a_fault_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && divide_fault |-> out_x == '0 && out_y == '0 && out_z == '0)
		else $error("fault with nonzero output");
	a_fault_nosat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && divide_fault |-> !saturated)
		else $error("fault and saturated together");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(saturated))
		else $error("output changed while stalled");
endmodule
`default_nettype wire

[bench/tb_vertex_matrix_transform_unit.sv]
// Testbench for the vertex matrix transform unit: directed tables, then random points with a predictor.
`default_nettype none
module tb_vertex_matrix_transform_unit;
	localparam int FRAC = 16;
	localparam int CW = 32;
	localparam int DRAIN_CYCLES = 120;
	localparam int RAND_ITEMS = 1030;

	typedef struct {
		logic [1:0] act;
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		bit known;
		logic [31:0] ex;
		logic [31:0] ey;
		logic [31:0] ez;
		bit efault;
		bit esat;
	} vertex_row_t;

	typedef struct {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		bit fault;
		bit sat;
	} xform_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [vmt_pkg::IDX_WIDTH-1:0] cfg_index = '0;
	logic [vmt_pkg::REG_WIDTH-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] action = vmt_pkg::ACT_FULL;
	logic signed [31:0] vec_x = '0, vec_y = '0, vec_z = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [31:0] out_x, out_y, out_z;
	logic divide_fault, saturated;

	vertex_matrix_transform_unit dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
		.action(action), .vec_x(vec_x), .vec_y(vec_y), .vec_z(vec_z),
		.out_valid(out_valid), .out_ready(out_ready), .out_x(out_x),
		.out_y(out_y), .out_z(out_z), .divide_fault(divide_fault),
		.saturated(saturated)
	);

	always #6 clk = ~clk;

	logic [63:0] matrix_regs [vmt_pkg::NUM_REGS];
	xform_res_t pending_points [$];
	int mismatches = 0;

	function automatic longint entry(int r, int c);
		logic [63:0] v;
		v = matrix_regs[(r - 1) * 2 + (c - 1) / 2];
		return ((c - 1) % 2) ? longint'($signed(v[31:0])) : longint'($signed(v[63:32]));
	endfunction

	// arithmetic shift on a 64-bit signed product floors toward minus infinity
	function automatic longint qmul(longint a, longint b);
		return (a * b) >>> FRAC;
	endfunction

	function automatic longint clip(longint v, ref bit flag);
		longint hi, lo;
		hi = (longint'(1) << (CW - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) begin
			flag = 1'b1;
			return hi;
		end
		if (v < lo) begin
			flag = 1'b1;
			return lo;
		end
		return v;
	endfunction

	function automatic longint qdiv(longint n, longint d, ref bit flag);
		bit neg;
		logic [63:0] un, ud, ip, rem, fr, maxmag, q;
		neg = (n < 0) != (d < 0);
		un = n < 0 ? -n : n;
		ud = d < 0 ? -d : d;
		ip = un / ud;
		rem = un % ud;
		fr = 0;
		maxmag = neg ? (64'd1 << (CW - 1)) : ((64'd1 << (CW - 1)) - 1);
		for (int i = 0; i < FRAC; i++) begin
			rem = rem << 1;
			fr = fr << 1;
			if (rem >= ud) begin
				rem = rem - ud;
				fr[0] = 1'b1;
			end
		end
		if (ip > (maxmag >> FRAC)) begin
			flag = 1'b1;
			q = maxmag;
		end else begin
			q = (ip << FRAC) | fr;
			if (q > maxmag) begin
				flag = 1'b1;
				q = maxmag;
			end
		end
		return neg ? -longint'(q) : longint'(q);
	endfunction

	function automatic xform_res_t transform_point(logic [1:0] act, logic [31:0] x,
			logic [31:0] y, logic [31:0] z);
		longint v[3], r[3], acc[4], s;
		xform_res_t res;
		bit fault, flag;
		v[0] = longint'($signed(x));
		v[1] = longint'($signed(y));
		v[2] = longint'($signed(z));
		r = '{0, 0, 0};
		fault = 1'b0;
		flag = 1'b0;
		if (act == vmt_pkg::ACT_FULL) begin
			for (int c = 1; c <= 4; c++)
				acc[c - 1] = qmul(v[0], entry(1, c)) + qmul(v[1], entry(2, c))
					+ qmul(v[2], entry(3, c)) + entry(4, c);
			if (acc[3] == 0)
				fault = 1'b1;
			else
				for (int k = 0; k < 3; k++)
					r[k] = qdiv(acc[k], acc[3], flag);
		end else if (act == vmt_pkg::ACT_ROT || act == vmt_pkg::ACT_INVROT) begin
			for (int c = 1; c <= 3; c++) begin
				s = 0;
				for (int k = 1; k <= 3; k++)
					s += qmul(v[k - 1], act == vmt_pkg::ACT_ROT ? entry(k, c) : entry(c, k));
				r[c - 1] = clip(s, flag);
			end
		end
		res.x = r[0][31:0];
		res.y = r[1][31:0];
		res.z = r[2][31:0];
		res.fault = fault;
		res.sat = flag;
		return res;
	endfunction

	task automatic reset_matrix();
		for (int i = 0; i < vmt_pkg::NUM_REGS; i++)
			matrix_regs[i] = '0;
		matrix_regs[vmt_pkg::REG_M11_M12] = 64'h0001_0000_0000_0000;
		matrix_regs[vmt_pkg::REG_M21_M22] = 64'h0000_0000_0001_0000;
		matrix_regs[vmt_pkg::REG_M33_M34] = 64'h0001_0000_0000_0000;
		matrix_regs[vmt_pkg::REG_M43_M44] = 64'h0000_0000_0001_0000;
	endtask

	// write enable drops for one cycle between writes
	task automatic write_reg(vmt_pkg::reg_idx_t idx, logic [63:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		matrix_regs[idx] = val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_points.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000 + $urandom_range(0, 3);
			1: return 32'h7FFF_FFFF - $urandom_range(0, 3);
			2: return $urandom_range(0, 32'h3_0000) - 32'h1_8000;
			3: return $urandom_range(0, 32'h400_0000) - 32'h200_0000;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] rand_entry();
		case ($urandom_range(0, 6))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0;
			3: return 32'h1_0000;
			4: return $urandom_range(0, 32'h4_0000) - 32'h2_0000;
			default: return $urandom;
		endcase
	endfunction

	// one request, pending the expected result before the handshake;
	// valid stays high into the next request when there is no gap
	task automatic send_point(logic [1:0] act, logic [31:0] x, logic [31:0] y,
			logic [31:0] z, xform_res_t expv);
		int gap;
		gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		vec_x <= x;
		vec_y <= y;
		vec_z <= z;
		pending_points.push_back(expv);
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// output side: random stall per result, compare on handshake
	initial begin : sink
		xform_res_t e;
		int stall;
		forever begin
			stall = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
			if (pending_points.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result x=%h y=%h z=%h", out_x, out_y, out_z);
			end else begin
				e = pending_points.pop_front();
				if (out_x !== e.x || out_y !== e.y || out_z !== e.z
						|| divide_fault !== e.fault || saturated !== e.sat) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp %h %h %h f%0b s%0b got %h %h %h f%0b s%0b",
							e.x, e.y, e.z, e.fault, e.sat, out_x, out_y, out_z,
							divide_fault, saturated);
				end
			end
		end
	end

	vertex_row_t directed_rows [] = '{
		'{vmt_pkg::ACT_FULL, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 1,
			32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 0, 0},
		'{vmt_pkg::ACT_ROT, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1,
			32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 0, 0},
		'{vmt_pkg::ACT_INVROT, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1,
			32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0, 0},
		'{vmt_pkg::ACT_NONE, 32'h1234_5678, 32'hFFFF_FFFF, 32'h8000_0000, 1,
			32'h0, 32'h0, 32'h0, 0, 0},
		'{vmt_pkg::ACT_FULL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0},
		'{vmt_pkg::ACT_FULL, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_0000, 1,
			32'h7FFF_FFFF, 32'h0, 32'hFFFF_0000, 0, 0},
		'{vmt_pkg::ACT_ROT, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0001_8000, 0, 0, 0, 0, 0, 0}
	};

	// scaled matrix with w taken from z: divide by zero at z == 0, clipping for large x
	vertex_row_t persp_rows [] = '{
		'{vmt_pkg::ACT_FULL, 32'h0001_0000, 32'h0001_0000, 32'h0, 1, 0, 0, 0, 1, 0},
		'{vmt_pkg::ACT_FULL, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 0, 0, 0, 0, 0, 0},
		'{vmt_pkg::ACT_FULL, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0},
		'{vmt_pkg::ACT_FULL, 32'h0003_0000, 32'hFFFE_0000, 32'h0002_0000, 0, 0, 0, 0, 0, 0},
		'{vmt_pkg::ACT_ROT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0, 0, 0, 0},
		'{vmt_pkg::ACT_INVROT, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, 0, 0, 0},
		'{vmt_pkg::ACT_NONE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 0, 0, 0, 0, 0}
	};

	task automatic run_rows(vertex_row_t rows []);
		xform_res_t e;
		foreach (rows[i]) begin
			if (rows[i].known) begin
				e.x = rows[i].ex;
				e.y = rows[i].ey;
				e.z = rows[i].ez;
				e.fault = rows[i].efault;
				e.sat = rows[i].esat;
			end else
				e = transform_point(rows[i].act, rows[i].x, rows[i].y, rows[i].z);
			send_point(rows[i].act, rows[i].x, rows[i].y, rows[i].z, e);
		end
	endtask

	initial begin : stimulus
		logic [1:0] act;
		logic [31:0] x, y, z;
		reset_matrix();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_rows(directed_rows);
		wait_idle();

		write_reg(vmt_pkg::REG_M11_M12, {32'h0002_0000, 32'h0});
		write_reg(vmt_pkg::REG_M13_M14, {32'h0, 32'h0});
		write_reg(vmt_pkg::REG_M21_M22, {32'h0, 32'h0002_0000});
		write_reg(vmt_pkg::REG_M23_M24, {32'h0, 32'h0});
		write_reg(vmt_pkg::REG_M31_M32, {32'h0, 32'h0});
		write_reg(vmt_pkg::REG_M33_M34, {32'h0001_0000, 32'h0001_0000});
		write_reg(vmt_pkg::REG_M41_M42, {32'h0, 32'h0});
		write_reg(vmt_pkg::REG_M43_M44, {32'h0, 32'h0});
		run_rows(persp_rows);
		wait_idle();

		for (int phase = 0; phase < 8; phase++) begin
			for (int r = 0; r < vmt_pkg::NUM_REGS; r++) begin
				if (phase == 3)
					write_reg(vmt_pkg::reg_idx_t'(r), 64'hFFFF_FFFF_FFFF_FFFF);
				else if (phase == 4)
					write_reg(vmt_pkg::reg_idx_t'(r), r % 2 ? 64'h8000_0000_7FFF_FFFF
						: 64'h7FFF_FFFF_8000_0000);
				else if (phase == 5)
					write_reg(vmt_pkg::reg_idx_t'(r), 64'h0);
				else
					write_reg(vmt_pkg::reg_idx_t'(r), {rand_entry(), rand_entry()});
			end
			// keep w mostly nonzero so divides get exercised
			if (phase != 5 && $urandom_range(0, 1))
				write_reg(vmt_pkg::REG_M43_M44, {rand_entry(), 32'h0001_0000});
			for (int i = 0; i < RAND_ITEMS / 8; i++) begin
				act = $urandom_range(0, 9) == 0 ? vmt_pkg::ACT_NONE
					: 2'($urandom_range(0, 2));
				x = rand_coord();
				y = rand_coord();
				z = rand_coord();
				send_point(act, x, y, z, transform_point(act, x, y, z));
			end
			wait_idle();
		end
		if (mismatches == 0 && pending_points.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin : watchdog
		#20_000_000;
		$display("== FAIL ==");
		$finish;
	end
endmodule
`default_nettype wire
